// ----- rtl/core/srga_pkg.sv -----
// Shared types and constants of the sparse row gradient accumulator.
package srga_pkg;

  // Row store geometry
  localparam int ROWS   = 4096;
  localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Field and arithmetic widths
  localparam int ROW_W  = 12;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 48;
  localparam int SUM_W  = 52;
  localparam int PROD_W = 64;
  localparam int FRAC_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BETA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MULT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_PEN  = 2'd2;

  // Configuration reset values
  localparam logic [VAL_W-1:0] BETA_RESET = 32'h0001_0000;

  // Input command codes
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture input beat, start row fetch
    logic mul_frame;  // beta * frame, capture fetched row sum
    logic mul_pen;    // form frame + multiplier term, beta * penalty
    logic sub_pen;    // subtract penalty term
    logic add_acc;    // add term to row sum
    logic wr_acc;     // store saturated sum
    logic wr_zero;    // clear row after read
    logic wr_clr;     // clearing pass write
    logic out_load;   // load output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_read;
    logic row_ok;
    logic clr_last;
  } dp_status_t;

endpackage

// ----- rtl/core/srga_ram.sv -----
// Generic simple dual-port RAM with registered read.
module srga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/srga_dp.sv -----
// Datapath: config registers, row store, shared multiplier, adder and output register.
module srga_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  srga_pkg::ctrl_cmd_t                   cmd,
  output srga_pkg::dp_status_t                  status,
  input  logic                                  cfg_we,
  input  logic [srga_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srga_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_command,
  input  logic [srga_pkg::ROW_W-1:0]            in_row_index,
  input  logic signed [srga_pkg::VAL_W-1:0]     in_multiplier_value,
  input  logic signed [srga_pkg::VAL_W-1:0]     in_penalty_value,
  input  logic signed [srga_pkg::VAL_W-1:0]     in_frame_value,
  output logic [srga_pkg::ROW_W-1:0]            out_row,
  output logic signed [srga_pkg::ACC_W-1:0]     out_row_sum
);

  localparam int AW = srga_pkg::ADDR_W;
  localparam int VW = srga_pkg::VAL_W;
  localparam int AccW = srga_pkg::ACC_W;
  localparam int SumW = srga_pkg::SUM_W;
  localparam int ProdW = srga_pkg::PROD_W;
  localparam int FracW = srga_pkg::FRAC_W;

  // Configuration
  logic [VW-1:0] beta_r;
  logic          use_mult_r;
  logic          use_pen_r;

  // Captured beat
  logic                            cmd_r;
  logic [srga_pkg::ROW_W-1:0]      row_r;
  logic signed [VW-1:0]            mult_r;
  logic signed [VW-1:0]            pen_r;
  logic signed [VW-1:0]            frame_r;

  // Arithmetic
  logic signed [AccW-1:0]          acc_r;
  logic signed [ProdW-1:0]         prod_r;
  logic signed [SumW-1:0]          term_r;
  logic signed [SumW-1:0]          sum_r;
  logic signed [VW-1:0]            mul_opnd;
  logic signed [2*VW+1:0]          prod_full;
  logic signed [AccW-1:0]          scaled;
  logic signed [SumW-1:0]          scaled_ext;
  logic signed [SumW-1:0]          mult_ext;
  logic signed [AccW-1:0]          sat_sum;

  // Clearing pass
  logic [AW-1:0]                   clr_addr_r;
  logic [AW-1:0]                   clr_addr_nxt;

  // Output register
  logic [srga_pkg::ROW_W-1:0]      out_row_r;
  logic signed [AccW-1:0]          out_sum_r;

  // RAM ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AccW-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [AccW-1:0] ram_rdata;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r     <= srga_pkg::BETA_RESET;
      use_mult_r <= 1'b1;
      use_pen_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        srga_pkg::REG_BETA:     beta_r     <= cfg_data;
        srga_pkg::REG_USE_MULT: use_mult_r <= cfg_data[0];
        srga_pkg::REG_USE_PEN:  use_pen_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      row_r   <= in_row_index;
      mult_r  <= in_multiplier_value;
      pen_r   <= in_penalty_value;
      frame_r <= in_frame_value;
    end
  end

  // Shared multiplier: unsigned beta times signed value, exact
  assign mul_opnd  = cmd.mul_pen ? pen_r : frame_r;
  assign prod_full = $signed({1'b0, beta_r}) * $signed({mul_opnd[VW-1], mul_opnd});

  // Floor shift of the held product back to Q.16
  assign scaled     = prod_r[ProdW-1:FracW];
  assign scaled_ext = {{(SumW-AccW){scaled[AccW-1]}}, scaled};
  assign mult_ext   = {{(SumW-VW){mult_r[VW-1]}}, mult_r};

  // Product, term and sum registers
  always_ff @(posedge clk) begin
    if (cmd.mul_frame || cmd.mul_pen) begin
      prod_r <= prod_full[ProdW-1:0];
    end
    if (cmd.mul_frame) begin
      acc_r <= ram_rdata;
    end
    if (cmd.mul_pen) begin
      term_r <= scaled_ext + (use_mult_r ? mult_ext : '0);
    end else if (cmd.sub_pen) begin
      term_r <= term_r - (use_pen_r ? scaled_ext : '0);
    end
    if (cmd.add_acc) begin
      sum_r <= {{(SumW-AccW){acc_r[AccW-1]}}, acc_r} + term_r;
    end
  end

  // Saturate to the signed accumulator range
  always_comb begin
    if (sum_r[SumW-1:AccW-1] == '0 || sum_r[SumW-1:AccW-1] == '1) begin
      sat_sum = sum_r[AccW-1:0];
    end else if (sum_r[SumW-1]) begin
      sat_sum = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(AccW-1){1'b1}}};
    end
  end

  // Advance the clearing address
  assign clr_addr_nxt = clr_addr_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.wr_clr) begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Row store
  assign ram_we    = cmd.wr_acc || cmd.wr_zero || cmd.wr_clr;
  assign ram_waddr = cmd.wr_clr ? clr_addr_r : AW'(row_r);
  assign ram_wdata = cmd.wr_acc ? sat_sum : '0;
  assign ram_raddr = AW'(in_row_index);

  srga_ram #(
    .WIDTH (AccW),
    .DEPTH (srga_pkg::ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r <= row_r;
      out_sum_r <= status.row_ok ? acc_r : '0;
    end
  end

  assign out_row     = out_row_r;
  assign out_row_sum = out_sum_r;

  // Status
  assign status.is_read  = (cmd_r == srga_pkg::CMD_READ);
  assign status.row_ok   = (32'(row_r) < 32'(srga_pkg::ROWS));
  assign status.clr_last = (clr_addr_r == AW'(srga_pkg::ROWS - 1));

endmodule

// ----- rtl/core/srga_ctrl.sv -----
// Controller: sequences clearing pass, accumulate and read beats.
module srga_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  srga_pkg::dp_status_t status,
  output srga_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_MULP  = 8'b0000_1000,
    S_SUB   = 8'b0001_0000,
    S_ADD   = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_clr = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.mul_frame = 1'b1;
        if (status.is_read) begin
          state_nxt = S_OUT;
        end else if (!status.row_ok) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MULP;
        end
      end
      S_MULP: begin
        cmd.mul_pen = 1'b1;
        state_nxt   = S_SUB;
      end
      S_SUB: begin
        cmd.sub_pen = 1'b1;
        state_nxt   = S_ADD;
      end
      S_ADD: begin
        cmd.add_acc = 1'b1;
        state_nxt   = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_acc = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.wr_zero  = status.row_ok;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output beat valid: set on load, drop when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/sparse_row_gradient_accumulator.sv -----
// Sparse row gradient accumulator: per-row saturating gradient sums in a 4096-row store.
// After reset the block runs a clearing pass over all 4096 rows (one row a cycle) and
// takes no input beat until it is done; configuration writes are taken at any time. An
// accumulate beat adds multiplier - beta*penalty + beta*frame (Q16.16, products floored
// to Q.16) to its row and saturates the sum at 48 bits; a read beat returns the row sum
// and clears the row. One input beat is in flight at a time, its steps set by the single
// shared 33x32 multiplier used twice per accumulate, the registered read of the row RAM
// and its read-modify-write; a read also waits for the output register to be free. A
// finished result sits in the output register while the next input beat is accepted.
module sparse_row_gradient_accumulator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [srga_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srga_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic [srga_pkg::ROW_W-1:0]            in_row_index,
  input  logic signed [srga_pkg::VAL_W-1:0]     in_multiplier_value,
  input  logic signed [srga_pkg::VAL_W-1:0]     in_penalty_value,
  input  logic signed [srga_pkg::VAL_W-1:0]     in_frame_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [srga_pkg::ROW_W-1:0]            out_row,
  output logic signed [srga_pkg::ACC_W-1:0]     out_row_sum
);

  srga_pkg::ctrl_cmd_t  cmd;
  srga_pkg::dp_status_t status;

  // Sequencer
  srga_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and row store
  srga_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_command          (in_command),
    .in_row_index        (in_row_index),
    .in_multiplier_value (in_multiplier_value),
    .in_penalty_value    (in_penalty_value),
    .in_frame_value      (in_frame_value),
    .out_row             (out_row),
    .out_row_sum         (out_row_sum)
  );

endmodule

// ----- verif/sparse_row_gradient_accumulator_test.sv -----
// Self-checking testbench for the sparse row gradient accumulator.
`timescale 1ns / 100ps

module sparse_row_gradient_accumulator_test;
  import srga_pkg::*;

  localparam int                   HALF_PERIOD    = 5;
  localparam int                   RESET_CYCLES   = 6;
  localparam int                   DRAIN_CYCLES   = 12;
  localparam int                   HOLD_CYCLES    = 300;
  localparam int                   QUIET_LIMIT    = 12000;
  localparam int                   PHASE_BEATS    = 160;
  localparam int                   PRESSURE_BEATS = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;

  // One expected read result
  typedef struct {
    logic [ROW_W-1:0] row;
    logic [ACC_W-1:0] sum;
  } row_sum_t;

  // Tracks row totals and the read results they imply
  class gradient_scoreboard;
    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic [VAL_W-1:0] beta;
    logic             use_mult;
    logic             use_pen;
    longint           row_totals[ROWS];
    row_sum_t         sums_due[$];
    int               errors;

    function new();
      beta     = BETA_RESET;
      use_mult = 1'b1;
      use_pen  = 1'b1;
      errors   = 0;
      foreach (row_totals[i]) row_totals[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_BETA:     beta = data[VAL_W-1:0];
        REG_USE_MULT: use_mult = data[0];
        REG_USE_PEN:  use_pen = data[0];
        default: ;
      endcase
    endfunction

    // Floor of beta * v / 2^16, exact in 64 bits
    function longint weigh(logic signed [VAL_W-1:0] v);
      longint p;
      p = longint'({32'b0, beta}) * longint'(v);
      return p >>> FRAC_W;
    endfunction

    function void note_beat(logic cmd, logic [ROW_W-1:0] row, logic signed [VAL_W-1:0] mult,
                            logic signed [VAL_W-1:0] pen, logic signed [VAL_W-1:0] frame);
      longint   term;
      longint   total;
      row_sum_t due;
      if (cmd == CMD_ACCUM) begin
        if (int'(row) >= ROWS) return;
        term = weigh(frame);
        if (use_mult) term += longint'(mult);
        if (use_pen) term -= weigh(pen);
        total = row_totals[row] + term;
        if (total > SUM_MAX) total = SUM_MAX;
        if (total < SUM_MIN) total = SUM_MIN;
        row_totals[row] = total;
      end else begin
        due.row = row;
        due.sum = '0;
        if (int'(row) < ROWS) begin
          due.sum = row_totals[row][ACC_W-1:0];
          row_totals[row] = 0;
        end
        sums_due.push_back(due);
      end
    endfunction

    function void check_sum(logic [ROW_W-1:0] row, logic [ACC_W-1:0] sum);
      row_sum_t due;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result row %0d sum %0d", $time, row, $signed(sum));
        errors++;
        return;
      end
      due = sums_due.pop_front();
      if (row !== due.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, due.row, row);
        errors++;
      end
      if (sum !== due.sum) begin
        $display("%0t: out_row_sum (row %0d) expected %0d actual %0d", $time, due.row,
                 $signed(due.sum), $signed(sum));
        errors++;
      end
    endfunction

    function int pending();
      return sums_due.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_command = CMD_ACCUM;
  logic [ROW_W-1:0]             in_row_index = '0;
  logic signed [VAL_W-1:0]      in_multiplier_value = '0;
  logic signed [VAL_W-1:0]      in_penalty_value = '0;
  logic signed [VAL_W-1:0]      in_frame_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [ROW_W-1:0]             out_row;
  logic signed [ACC_W-1:0]      out_row_sum;

  gradient_scoreboard sb = new();
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_request = 1'b0;
  int                 quiet_cycles = 0;
  logic [ROW_W-1:0]   hot_rows[8];

  sparse_row_gradient_accumulator u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_row_index        (in_row_index),
    .in_multiplier_value (in_multiplier_value),
    .in_penalty_value    (in_penalty_value),
    .in_frame_value      (in_frame_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_row             (out_row),
    .out_row_sum         (out_row_sum)
  );

  always #HALF_PERIOD clk = ~clk;

  // Observe both channels and the config port on every edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_sum(out_row, out_row_sum);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        sb.note_beat(in_command, in_row_index, in_multiplier_value, in_penalty_value,
                     in_frame_value);
      end
    end
  end

  // Drive result-side backpressure; serve a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted
  task automatic send_beat(logic cmd, logic [ROW_W-1:0] row, logic [VAL_W-1:0] mult,
                           logic [VAL_W-1:0] pen, logic [VAL_W-1:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_row_index        <= row;
    in_multiplier_value <= mult;
    in_penalty_value    <= pen;
    in_frame_value      <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write every register, the unused index too, then drop the write enable
  task automatic apply_config(logic [VAL_W-1:0] b, logic um, logic up);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BETA;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= REG_USE_MULT;
    cfg_data  <= {31'b0, um};
    @(posedge clk);
    cfg_index <= REG_USE_PEN;
    cfg_data  <= {31'b0, up};
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every read result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(9))
      0:       return ROW_W'($urandom_range(4095));
      1:       return $urandom_range(1) ? '1 : '0;
      default: return hot_rows[$urandom_range(7)];
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return VAL_W'($urandom_range(131071)) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_beat();
    logic cmd;
    cmd = ($urandom_range(3) == 0) ? CMD_READ : CMD_ACCUM;
    send_beat(cmd, pick_row(), pick_value(), pick_value(), pick_value());
  endtask

  initial begin
    logic [VAL_W-1:0] b;
    logic             um;
    logic             up;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes at unit weight, reads of cleared and untouched rows
    apply_config(BETA_RESET, 1'b1, 1'b1);
    send_beat(CMD_ACCUM, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(CMD_ACCUM, 12'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(CMD_ACCUM, 12'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
    send_beat(CMD_READ, 12'd0, $urandom, $urandom, $urandom);
    send_beat(CMD_READ, 12'd0, $urandom, $urandom, $urandom);
    send_beat(CMD_ACCUM, 12'hFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_beat(CMD_READ, 12'hFFF, $urandom, $urandom, $urandom);
    send_beat(CMD_READ, 12'hAAA, $urandom, $urandom, $urandom);
    send_beat(CMD_ACCUM, 12'h555, $urandom, $urandom, $urandom);
    send_beat(CMD_READ, 12'h555, $urandom, $urandom, $urandom);
    drain();

    // Directed: maximum weight with both optional terms dropped, saturate both ways
    apply_config(32'hFFFF_FFFF, 1'b0, 1'b0);
    repeat (3) send_beat(CMD_ACCUM, 12'd7, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(CMD_READ, 12'd7, $urandom, $urandom, $urandom);
    repeat (3) send_beat(CMD_ACCUM, 12'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(CMD_READ, 12'd8, $urandom, $urandom, $urandom);
    send_beat(CMD_ACCUM, 12'd9, $urandom, $urandom, 32'hFFFF_FFFF);
    send_beat(CMD_READ, 12'd9, $urandom, $urandom, $urandom);
    drain();

    // Directed: zero weight leaves the multiplier only
    apply_config(32'd0, 1'b1, 1'b1);
    send_beat(CMD_ACCUM, 12'd3, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(CMD_ACCUM, 12'd3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(CMD_READ, 12'd3, $urandom, $urandom, $urandom);
    drain();

    // Directed: smallest weight, products of -1 floor to -1
    apply_config(32'd1, 1'b1, 1'b1);
    send_beat(CMD_ACCUM, 12'd5, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_beat(CMD_READ, 12'd5, $urandom, $urandom, $urandom);
    drain();

    // Random phases over a small set of hot rows, cycling idle patterns
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin b = BETA_RESET;   um = 1'b1; up = 1'b1; end
        1: begin b = 32'hFFFF_FFFF; um = 1'b1; up = 1'b1; end
        2: begin b = 32'd1;        um = 1'b0; up = 1'b1; end
        3: begin b = 32'd0;        um = 1'b1; up = 1'b0; end
        default: begin
          b  = $urandom_range(1) ? $urandom : VAL_W'($urandom_range(262143));
          um = 1'($urandom_range(1));
          up = 1'($urandom_range(1));
        end
      endcase
      apply_config(b, um, up);
      foreach (hot_rows[i]) hot_rows[i] = ROW_W'($urandom_range(4095));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      repeat (PHASE_BEATS) random_beat();
      drain();
    end

    // Hold the result side off while beats keep coming, then wait it out
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    for (int i = 0; i < PRESSURE_BEATS; i++) begin
      send_beat((i % 2) ? CMD_READ : CMD_ACCUM, hot_rows[i % 4], $urandom, $urandom, $urandom);
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/srga_pkg.sv
rtl/core/srga_ram.sv
rtl/core/srga_dp.sv
rtl/core/srga_ctrl.sv
rtl/core/sparse_row_gradient_accumulator.sv
verif/sparse_row_gradient_accumulator_test.sv
